### hw/rtl/rtpp_pkg.sv
// Package: shared types, constants and register indexes of the RTP packetizer.
`timescale 1ns / 1ps

package rtpp_pkg;

  // Largest payload of one packet, in bytes.
  localparam int PAYLOAD_MAX = 1400;

  // Width of the fill counter; it must be able to hold PAYLOAD_MAX itself.
  localparam int FILL_W = $clog2(PAYLOAD_MAX + 1);

  // Field widths fixed by the interface.
  localparam int LEN_W   = 11;
  localparam int SEQ_W   = 16;
  localparam int PT_W    = 7;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 32;

  // Fixed header constants.
  localparam logic [SEQ_W-1:0] SEQ_RESET     = 16'd65000;
  localparam logic [PT_W-1:0]  PT_RESET      = 7'd96;
  localparam logic [7:0]       DOLLAR        = 8'h24;
  localparam logic [15:0]      RTP_HDR_BYTES = 16'd12;
  localparam logic [1:0]       RTP_VERSION   = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_PAYLOAD_TYPE   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SOURCE_ID      = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TCP_INTERLEAVE = 2'd2;

  // Result kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_DESC = 1'b1;

  // Which result of the held item is emitted next.
  typedef enum logic [1:0] {
    PH_BYTE,
    PH_FULL,
    PH_LAST
  } rtpp_phase_t;

  // Current configuration.
  typedef struct packed {
    logic [PT_W-1:0] payload_type;
    logic [31:0]     source_id;
    logic            tcp_interleave;
  } rtpp_cfg_t;

  // One result item.
  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic [31:0]      header_word0;
    logic [31:0]      header_ssrc;
    logic [31:0]      interleave_word;
    logic [LEN_W-1:0] payload_len;
    logic             marker;
    logic             run_last;
  } rtpp_result_t;

endpackage

### hw/rtl/rtpp_cfg_regs.sv
// Configuration registers of the RTP packetizer.
`timescale 1ns / 1ps

module rtpp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rtpp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [rtpp_pkg::CDATA_W-1:0]  cfg_data,
  output rtpp_pkg::rtpp_cfg_t           cfg
);

  // Writes are always taken, with no wait.
  assign cfg_ready = 1'b1;

  // Register file; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_type   <= rtpp_pkg::PT_RESET;
      cfg.source_id      <= '0;
      cfg.tcp_interleave <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtpp_pkg::CFG_PAYLOAD_TYPE:   cfg.payload_type   <= cfg_data[rtpp_pkg::PT_W-1:0];
        rtpp_pkg::CFG_SOURCE_ID:      cfg.source_id      <= cfg_data[31:0];
        rtpp_pkg::CFG_TCP_INTERLEAVE: cfg.tcp_interleave <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/rtpp_packet_ctrl.sv
// Input register, packet fill counter, sequence counter and result builder.
`timescale 1ns / 1ps

module rtpp_packet_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             payload_byte,
  input  logic                   frame_last,
  input  rtpp_pkg::rtpp_cfg_t    cfg,
  input  logic                   emit_ready,
  output logic                   res_valid,
  output rtpp_pkg::rtpp_result_t res
);

  // Held item and its progress.
  logic                        hold_valid;
  rtpp_pkg::rtpp_phase_t       phase;
  rtpp_pkg::rtpp_phase_t       phase_next;
  logic [7:0]                  item_byte;
  logic                        item_full;
  logic                        item_last;
  logic [rtpp_pkg::FILL_W-1:0] item_len;

  // Packet state.
  logic [rtpp_pkg::FILL_W-1:0] fill_count;
  logic [rtpp_pkg::SEQ_W-1:0]  seq_num;

  logic                        emit;
  logic                        done;
  logic                        accept;
  logic [rtpp_pkg::FILL_W-1:0] fill_inc;
  logic                        reach_full;
  logic                        is_desc;
  logic                        desc_full;
  logic [rtpp_pkg::FILL_W-1:0] desc_len;
  logic [15:0]                 desc_len16;
  logic [rtpp_pkg::SEQ_W-1:0]  seq_inc;

  // Byte count after this one, and whether it fills the packet.
  assign fill_inc   = fill_count + rtpp_pkg::FILL_W'(1);
  assign reach_full = (fill_inc == rtpp_pkg::FILL_W'(rtpp_pkg::PAYLOAD_MAX));

  // Step through byte, full descriptor and final descriptor as the item needs.
  always_comb begin
    phase_next = rtpp_pkg::PH_BYTE;
    done       = 1'b1;
    unique case (phase)
      rtpp_pkg::PH_BYTE: begin
        if (item_full) begin
          phase_next = rtpp_pkg::PH_FULL;
          done       = 1'b0;
        end else if (item_last) begin
          phase_next = rtpp_pkg::PH_LAST;
          done       = 1'b0;
        end
      end
      rtpp_pkg::PH_FULL: begin
        if (item_last) begin
          phase_next = rtpp_pkg::PH_LAST;
          done       = 1'b0;
        end
      end
      rtpp_pkg::PH_LAST: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // Handshake: a new item enters as the held one hands over its last result.
  assign emit      = hold_valid && emit_ready;
  assign in_stall  = hold_valid && !(emit_ready && done);
  assign accept    = in_valid && !in_stall;
  assign res_valid = hold_valid;

  // Item register, fill counter and progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= rtpp_pkg::PH_BYTE;
      fill_count <= '0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
        phase      <= rtpp_pkg::PH_BYTE;
        fill_count <= (reach_full || frame_last) ? '0 : fill_inc;
      end else if (emit) begin
        hold_valid <= !done;
        phase      <= phase_next;
      end
    end
  end

  // Payload of the held item; the final length is zero after a full close.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte <= payload_byte;
      item_full <= reach_full;
      item_last <= frame_last;
      item_len  <= reach_full ? '0 : fill_inc;
    end
  end

  // Sequence number advances with each descriptor sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_num <= rtpp_pkg::SEQ_RESET;
    end else if (emit && is_desc) begin
      seq_num <= seq_inc;
    end
  end

  // Result fields for the current phase.
  assign is_desc    = (phase != rtpp_pkg::PH_BYTE);
  assign desc_full  = (phase == rtpp_pkg::PH_FULL);
  assign desc_len   = desc_full ? rtpp_pkg::FILL_W'(rtpp_pkg::PAYLOAD_MAX) : item_len;
  assign desc_len16 = 16'(desc_len);
  assign seq_inc    = seq_num + rtpp_pkg::SEQ_W'(1);

  always_comb begin
    res = '0;
    if (is_desc) begin
      res.kind         = rtpp_pkg::KIND_DESC;
      res.header_word0 = {rtpp_pkg::RTP_VERSION, 1'b0, 1'b0, 4'd0, !desc_full,
                          cfg.payload_type, seq_inc};
      res.header_ssrc  = cfg.source_id;
      if (cfg.tcp_interleave) begin
        res.interleave_word = {rtpp_pkg::DOLLAR, 8'h00, desc_len16 + rtpp_pkg::RTP_HDR_BYTES};
      end
      res.payload_len  = rtpp_pkg::LEN_W'(desc_len);
      res.marker       = !desc_full;
    end else begin
      res.kind      = rtpp_pkg::KIND_BYTE;
      res.data_byte = item_byte;
    end
    res.run_last = done;
  end

endmodule

### hw/rtl/rtpp_out_stage.sv
// Output register of the RTP packetizer.
`timescale 1ns / 1ps

module rtpp_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  rtpp_pkg::rtpp_result_t res,
  output logic                   emit_ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rtpp_pkg::rtpp_result_t out_res
);

  // The register takes a new result when empty or when its content leaves.
  assign emit_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

### hw/rtl/rtp_payload_packetizer_top.sv
// Top level of the RTP payload packetizer with optional interleave word.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-----------------------------------------
//  input    | in_valid / in_stall   | payload_byte, frame_last
//  output   | out_valid / out_stall | kind, data_byte, header_word0,
//           |                       | header_ssrc, interleave_word,
//           |                       | payload_len, marker, run_last
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each byte goes through the item register, then the output register. Unless
// the output stalls, a byte closing no packet lets the next in every cycle.
// A byte closing a packet stays until its descriptor is out; a frame end on a
// packet boundary adds a final one, one result per cycle while unstalled.
// Synchronous reset clears the fill counter, the valid flags, the source id and
// interleave flag, and loads the sequence number and payload type reset values.
// A stall on the output holds the output register and, through it, the input.
`timescale 1ns / 1ps

module rtp_payload_packetizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          payload_byte,
  input  logic                                frame_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                kind,
  output logic [7:0]                          data_byte,
  output logic [31:0]                         header_word0,
  output logic [31:0]                         header_ssrc,
  output logic [31:0]                         interleave_word,
  output logic [rtpp_pkg::LEN_W-1:0]          payload_len,
  output logic                                marker,
  output logic                                run_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtpp_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [rtpp_pkg::CDATA_W-1:0]        cfg_data
);

  rtpp_pkg::rtpp_cfg_t    cfg;
  rtpp_pkg::rtpp_result_t res;
  rtpp_pkg::rtpp_result_t out_res;
  logic                   res_valid;
  logic                   emit_ready;

  // Configuration registers.
  rtpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Packet control and result building.
  rtpp_packet_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .payload_byte (payload_byte),
    .frame_last   (frame_last),
    .cfg          (cfg),
    .emit_ready   (emit_ready),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Output register.
  rtpp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .emit_ready (emit_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  // Result fields onto their ports.
  assign kind            = out_res.kind;
  assign data_byte       = out_res.data_byte;
  assign header_word0    = out_res.header_word0;
  assign header_ssrc     = out_res.header_ssrc;
  assign interleave_word = out_res.interleave_word;
  assign payload_len     = out_res.payload_len;
  assign marker          = out_res.marker;
  assign run_last        = out_res.run_last;

endmodule

### tb/sv/rtp_payload_packetizer_top_tb.sv
// Testbench for the RTP payload packetizer: directed and random frames checked against a scoreboard.
`timescale 1ns / 1ps

module rtp_payload_packetizer_top_tb;
  import rtpp_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 4;
  localparam int QUIET_LIMIT    = 3000;
  localparam int PHASE_ITEMS    = 115;
  localparam int WRAP_FRAMES    = 540;
  localparam int REPORT_LIMIT   = 10;
  // Index past the register list; writes to it must change nothing.
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

  // Expected-result store and predictor of the packetizer.
  class packet_stream_board;
    rtpp_cfg_t      cfg;
    logic [SEQ_W-1:0] seq_num;
    int unsigned    fill;
    rtpp_result_t   awaited_results[$];
    int unsigned    mismatch_count;

    function new();
      cfg.payload_type   = PT_RESET;
      cfg.source_id      = '0;
      cfg.tcp_interleave = 1'b0;
      seq_num            = SEQ_RESET;
      fill               = 0;
      mismatch_count     = 0;
    endfunction

    function void note_config(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      case (idx)
        CFG_PAYLOAD_TYPE:   cfg.payload_type   = data[PT_W-1:0];
        CFG_SOURCE_ID:      cfg.source_id      = data;
        CFG_TCP_INTERLEAVE: cfg.tcp_interleave = data[0];
        default: ;
      endcase
    endfunction

    // Closes a packet: the sequence number is advanced before it is used.
    function rtpp_result_t close_packet(int unsigned len, logic mark);
      rtpp_result_t d;
      logic [15:0] len16;
      seq_num = seq_num + 16'd1;
      len16 = 16'(len);
      d = '0;
      d.kind = KIND_DESC;
      d.header_word0 = {RTP_VERSION, 1'b0, 1'b0, 4'd0, mark, cfg.payload_type, seq_num};
      d.header_ssrc = cfg.source_id;
      if (cfg.tcp_interleave) begin
        d.interleave_word = {DOLLAR, 8'h00, len16 + RTP_HDR_BYTES};
      end
      d.payload_len = LEN_W'(len);
      d.marker = mark;
      return d;
    endfunction

    // Works out the results of one accepted payload byte.
    function void note_byte(logic [7:0] b, logic last);
      rtpp_result_t res[3];
      int n;
      logic closed_full;
      res[0] = '0;
      res[0].kind = KIND_BYTE;
      res[0].data_byte = b;
      n = 1;
      closed_full = 1'b0;
      fill++;
      if (fill >= PAYLOAD_MAX) begin
        res[n] = close_packet(PAYLOAD_MAX, 1'b0);
        n++;
        fill = 0;
        closed_full = 1'b1;
      end
      // A frame ending on a packet boundary gets an empty marker packet.
      if (last) begin
        res[n] = close_packet(closed_full ? 0 : fill, 1'b1);
        n++;
        fill = 0;
      end
      res[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) begin
        awaited_results = {awaited_results, res[i]};
      end
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, exp_v, act_v);
      end
    endfunction

    function void check_result(rtpp_result_t got);
      rtpp_result_t exp_r;
      if (awaited_results.size() == 0) begin
        report("unexpected result, kind", 32'hFFFF_FFFF, 32'(got.kind));
        return;
      end
      exp_r = awaited_results.pop_front();
      if (got.kind !== exp_r.kind) report("kind", 32'(exp_r.kind), 32'(got.kind));
      if (got.data_byte !== exp_r.data_byte) begin
        report("data_byte", 32'(exp_r.data_byte), 32'(got.data_byte));
      end
      if (got.header_word0 !== exp_r.header_word0) begin
        report("header_word0", exp_r.header_word0, got.header_word0);
      end
      if (got.header_ssrc !== exp_r.header_ssrc) begin
        report("header_ssrc", exp_r.header_ssrc, got.header_ssrc);
      end
      if (got.interleave_word !== exp_r.interleave_word) begin
        report("interleave_word", exp_r.interleave_word, got.interleave_word);
      end
      if (got.payload_len !== exp_r.payload_len) begin
        report("payload_len", 32'(exp_r.payload_len), 32'(got.payload_len));
      end
      if (got.marker !== exp_r.marker) report("marker", 32'(exp_r.marker), 32'(got.marker));
      if (got.run_last !== exp_r.run_last) begin
        report("run_last", 32'(exp_r.run_last), 32'(got.run_last));
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [7:0]          payload_byte = '0;
  logic                frame_last   = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                kind;
  logic [7:0]          data_byte;
  logic [31:0]         header_word0;
  logic [31:0]         header_ssrc;
  logic [31:0]         interleave_word;
  logic [LEN_W-1:0]    payload_len;
  logic                marker;
  logic                run_last;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index    = '0;
  logic [CDATA_W-1:0]  cfg_data     = '0;

  packet_stream_board stream_board = new();
  int gap_pct   = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  rtp_payload_packetizer_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .payload_byte    (payload_byte),
    .frame_last      (frame_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .data_byte       (data_byte),
    .header_word0    (header_word0),
    .header_ssrc     (header_ssrc),
    .interleave_word (interleave_word),
    .payload_len     (payload_len),
    .marker          (marker),
    .run_last        (run_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      stream_board.check_result({kind, data_byte, header_word0, header_ssrc,
                                 interleave_word, payload_len, marker, run_last});
    end
  end

  // Watchdog: the run ends if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one payload byte, after a random gap, and holds it until taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ((gap_pct > 0) && ($urandom_range(0, 99) < gap_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    payload_byte <= b;
    frame_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stream_board.note_byte(b, last);
  endtask

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Holds the input back until every expected result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (stream_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    stream_board.note_config(idx, data);
  endtask

  // Writes every register, plus one write to the unused index.
  task automatic configure(input logic [CDATA_W-1:0] pt, input logic [CDATA_W-1:0] ssrc,
                           input logic [CDATA_W-1:0] tcp);
    write_reg(CFG_PAYLOAD_TYPE, pt);
    write_reg(CFG_SOURCE_ID, ssrc);
    write_reg(CFG_TCP_INTERLEAVE, tcp);
    write_reg(CFG_SPARE, $urandom());
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CDATA_W-1:0] pick_word(input logic [CDATA_W-1:0] top);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return top;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int sent;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset configuration: byte extremes, short frames.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h0F, 1'b1);

    // Register extremes, with interleave words, then everything cleared.
    wait_drained();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    wait_drained();
    configure(32'h0, 32'h0, 32'h0);
    send_byte(8'h81, 1'b1);

    // A frame filling exactly one packet, then one a byte longer.
    wait_drained();
    configure(32'h55, 32'h1234_5678, 32'h1);
    send_frame(PAYLOAD_MAX);
    send_frame(PAYLOAD_MAX + 1);

    // Enough one-byte frames to take the sequence number through its wrap.
    repeat (WRAP_FRAMES) send_frame(1);

    // Random frames in four phases of input gaps and output stalls, with fresh registers for each.
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 60; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 60; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      configure(pick_word(32'h7F), pick_word(32'hFFFF_FFFF), 32'(ph % 2));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        int unsigned len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
        send_frame(len);
        sent += len;
        // Mid-way through one phase the sender waits for the output to empty.
        if (ph == 1 && sent >= PHASE_ITEMS / 2 && sent - len < PHASE_ITEMS / 2) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (stream_board.pending() != 0) begin
      $display("%0d expected results never arrived", stream_board.pending());
    end
    if (stream_board.mismatch_count == 0 && stream_board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
